// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define LGE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define LGE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/lge_pkg.sv =====
`timescale 1ns / 1ps

package lge_pkg;

  // request field widths
  localparam int REQ_W = 2;
  localparam int COL_W = 7;
  localparam int ROW_W = 6;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TOGGLE  = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

endpackage

// ===== rtl/core/life_grid_engine_top.sv =====
`timescale 1ns / 1ps

// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------
// in       | in_valid / in_stall       | req_type[1:0], col[6:0], row[5:0]
// out      | out_valid / out_stall     | cell_state, accepted
//
// toggle and read pass through S_CELL and S_DONE from accept to result beat,
// clear and an out-of-grid toggle or read go straight to S_DONE, and an
// advance runs S_LOAD, S_SWEEP and S_DONE: the generation sweep writes back
// one column per cycle via the column store's single read and write ports.
// in_stall is high from the accept until the result sits in the output
// register; a stalled result beat holds and the block waits to hand over the
// next one. reset (sync, active high) kills all column valid bits at once, so
// the grid reads as all dead without any clearing pass.

module life_grid_engine_top #(
  parameter int COLS = 80,
  parameter int ROWS = 60
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lge_pkg::REQ_W-1:0] req_type,
  input  logic [lge_pkg::COL_W-1:0] col,
  input  logic [lge_pkg::ROW_W-1:0] row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      cell_state,
  output logic                      accepted
);

  import lge_pkg::*;

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CNT_W = $clog2(COLS + 1);

  localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLS);
  localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);
  localparam logic [CW-1:0]    LAST_COL = CW'(COLS - 1);
  localparam logic [CNT_W-1:0] COL_END  = CNT_W'(COLS);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request beat
    S_CELL,   // column of a toggle or read on its way out of the store
    S_LOAD,   // first column of a generation sweep arriving
    S_SWEEP,  // one column rewritten per cycle
    S_DONE    // result waiting for the output register
  } state_t;

  state_t state;

  // request held for the duration of the item
  req_t            req_q;
  logic [CW-1:0]   caddr;
  logic [RW-1:0]   rbit;
  logic            res_state;
  logic            res_ok;

  // sweep counters and the three-column window
  logic [CW-1:0]    wr_idx;
  logic [CNT_W-1:0] rd_idx;
  logic [ROWS-1:0]  prev_col;
  logic [ROWS-1:0]  mid_col;

  // column store, one word per column, bit r is row r
  logic [ROWS-1:0] mem [COLS];
  logic [COLS-1:0] col_vld;
  logic [ROWS-1:0] mem_q;
  logic            vld_q;

  logic            mem_re;
  logic [CW-1:0]   mem_raddr;
  logic            mem_we;
  logic [CW-1:0]   mem_waddr;
  logic [ROWS-1:0] mem_wdata;

  logic            in_go;
  logic            in_range;
  logic            clear_go;
  logic            out_free;
  logic [ROWS-1:0] rdata;
  logic [ROWS-1:0] right_col;
  logic [ROWS-1:0] gen_col;
  logic [ROWS+1:0] pad_l;
  logic [ROWS+1:0] pad_m;
  logic [ROWS+1:0] pad_r;
  logic [3:0]      nbr [ROWS];

  assign in_stall = (state != S_IDLE);
  assign in_go    = in_valid && !in_stall;
  assign in_range = ({1'b0, col} < COL_LIM) && ({1'b0, row} < ROW_LIM);
  assign clear_go = in_go && (req_t'(req_type) == REQ_CLEAR);
  assign out_free = !out_valid || !out_stall;

  // a column never written since reset or clear reads as all dead
  assign rdata     = vld_q ? mem_q : '0;
  assign right_col = (wr_idx == LAST_COL) ? '0 : rdata;

  // column rule unit: neighbour counts for every row of the middle column,
  // rows outside the grid padded with dead cells
  assign pad_l = {1'b0, prev_col, 1'b0};
  assign pad_m = {1'b0, mid_col, 1'b0};
  assign pad_r = {1'b0, right_col, 1'b0};

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      nbr[r] = {3'b000, pad_l[r]} + {3'b000, pad_l[r+1]} + {3'b000, pad_l[r+2]}
             + {3'b000, pad_r[r]} + {3'b000, pad_r[r+1]} + {3'b000, pad_r[r+2]}
             + {3'b000, pad_m[r]} + {3'b000, pad_m[r+2]};
      // born with three, survives with two or three
      gen_col[r] = (nbr[r] == 4'd3) || (mid_col[r] && (nbr[r] == 4'd2));
    end
  end

  // store read port
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_idx[CW-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_go) begin
          unique case (req_t'(req_type)) inside
            REQ_TOGGLE, REQ_READ: begin
              mem_re    = in_range;
              mem_raddr = col[CW-1:0];
            end
            REQ_ADVANCE: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      S_LOAD:  mem_re = 1'b1;
      S_SWEEP: mem_re = (rd_idx < COL_END);
      default: mem_re = 1'b0;
    endcase
  end

  // store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = gen_col;
    unique case (state)
      S_CELL: begin
        mem_we    = (req_q == REQ_TOGGLE);
        mem_waddr = caddr;
        mem_wdata = rdata ^ (ROWS'(1) << rbit);
      end
      S_SWEEP: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
      vld_q <= col_vld[mem_raddr];
    end
  end

  // column valid bits: reset and clear kill the whole grid at once
  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      col_vld <= '0;
    end else if (mem_we) begin
      col_vld[mem_waddr] <= 1'b1;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a taken beat empties the output register unless the next one moves in
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_go) begin
            req_q    <= req_t'(req_type);
            caddr    <= col[CW-1:0];
            rbit     <= row[RW-1:0];
            prev_col <= '0;
            unique case (req_t'(req_type)) inside
              REQ_TOGGLE, REQ_READ: begin
                if (in_range) begin
                  state <= S_CELL;
                end else begin
                  res_state <= 1'b0;
                  res_ok    <= 1'b0;
                  state     <= S_DONE;
                end
              end
              REQ_ADVANCE: begin
                rd_idx <= CNT_W'(1);
                wr_idx <= '0;
                state  <= S_LOAD;
              end
              default: begin
                res_state <= 1'b0;
                res_ok    <= 1'b1;
                state     <= S_DONE;
              end
            endcase
          end
        end
        S_CELL: begin
          res_state <= rdata[rbit] ^ (req_q == REQ_TOGGLE);
          res_ok    <= 1'b1;
          state     <= S_DONE;
        end
        S_LOAD: begin
          mid_col <= rdata;
          rd_idx  <= rd_idx + CNT_W'(1);
          state   <= S_SWEEP;
        end
        S_SWEEP: begin
          // slide the window: old middle becomes the left neighbour
          prev_col <= mid_col;
          mid_col  <= right_col;
          if (rd_idx < COL_END) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (wr_idx == LAST_COL) begin
            res_state <= 1'b0;
            res_ok    <= 1'b1;
            state     <= S_DONE;
          end else begin
            wr_idx <= wr_idx + CW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            cell_state <= res_state;
            accepted   <= res_ok;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lge_chk.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lge_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cell_state,
  input logic accepted
);

  // a held result beat keeps its payload
  `LGE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cell_state) && $stable(accepted))

  // one item at a time: busy right after an accept
  `LGE_ASSERT_NEXT(a_busy_after_go, clk, rst, in_valid && !in_stall, in_stall)

  // a live cell is only reported for a performed request
  `LGE_ASSERT_IMPL(a_state_needs_ok, clk, rst, out_valid && cell_state, accepted)

  // a new result only comes out of an item in flight
  `LGE_ASSERT_IMPL(a_result_from_busy, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind life_grid_engine_top lge_chk u_lge_chk (.*);
